/* src/tmcw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tmcw_pkg;

	localparam int OP_W   = 2;
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int DATA_W = 16;
	localparam int ATTR_W = 8;

	localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h0f;

	localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0a;
	localparam logic [CHAR_W-1:0] CH_ENTER     = 8'h0d;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

	localparam int TAB_W = 3;
	localparam logic [TAB_W-1:0] TAB_SPACES = 3'd4;

	localparam int KIND_W = 3;
	localparam logic [KIND_W-1:0] K_PUT     = 3'd0;
	localparam logic [KIND_W-1:0] K_TAB     = 3'd1;
	localparam logic [KIND_W-1:0] K_NEWLINE = 3'd2;
	localparam logic [KIND_W-1:0] K_BKSP    = 3'd3;
	localparam logic [KIND_W-1:0] K_CLEAR   = 3'd4;
	localparam logic [KIND_W-1:0] K_READ    = 3'd5;
	localparam logic [KIND_W-1:0] K_NOP     = 3'd6;

	localparam int FIFO_DEPTH = 2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CHAR_W-1:0] ch;
		logic [IDX_W-1:0]  idx;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

endpackage

`default_nettype wire

/* src/tmcw_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module tmcw_front (
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [tmcw_pkg::OP_W-1:0]   op,
	input  wire logic [tmcw_pkg::CHAR_W-1:0] char_code,
	input  wire logic [tmcw_pkg::IDX_W-1:0]  cell_index,
	input  wire tmcw_pkg::fifo_stat_t        fifo_stat,
	input  wire logic                       init_busy,
	output logic                            push,
	output tmcw_pkg::cmd_t                  cmd
);

	logic [tmcw_pkg::KIND_W-1:0] kind;

	always_comb begin
		case (op)
			tmcw_pkg::OP_PUT: begin
				case (char_code)
					tmcw_pkg::CH_NEWLINE:   kind = tmcw_pkg::K_NEWLINE;
					tmcw_pkg::CH_ENTER:     kind = tmcw_pkg::K_NEWLINE;
					tmcw_pkg::CH_BACKSPACE: kind = tmcw_pkg::K_BKSP;
					tmcw_pkg::CH_TAB:       kind = tmcw_pkg::K_TAB;
					default:                kind = tmcw_pkg::K_PUT;
				endcase
			end
			tmcw_pkg::OP_CLEAR: kind = tmcw_pkg::K_CLEAR;
			tmcw_pkg::OP_READ:  kind = tmcw_pkg::K_READ;
			default:            kind = tmcw_pkg::K_NOP;
		endcase
	end

	assign in_ready = !fifo_stat.full && !init_busy;
	assign push     = in_valid && in_ready;
	assign cmd.kind = kind;
	assign cmd.ch   = char_code;
	assign cmd.idx  = cell_index;

endmodule

`default_nettype wire

/* src/tmcw_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module tmcw_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire tmcw_pkg::cmd_t      push_cmd,
	input  wire logic                pop,
	output tmcw_pkg::cmd_t           pop_cmd,
	output tmcw_pkg::fifo_stat_t     stat
);

	localparam int PW = $clog2(tmcw_pkg::FIFO_DEPTH);
	localparam int CW = $clog2(tmcw_pkg::FIFO_DEPTH + 1);

	tmcw_pkg::cmd_t  entry_q [tmcw_pkg::FIFO_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(tmcw_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(tmcw_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign pop_cmd    = entry_q[rd_ptr_q];
	assign stat.full  = (count_q == CW'(tmcw_pkg::FIFO_DEPTH));
	assign stat.empty = (count_q == '0);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		stat.full |-> !push || pop)
		else $error("transfer into full queue");

endmodule

`default_nettype wire

/* src/tmcw_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module tmcw_back #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [tmcw_pkg::ATTR_W-1:0] attr,
	input  wire tmcw_pkg::fifo_stat_t        fifo_stat,
	input  wire tmcw_pkg::cmd_t              cmd,
	output logic                             pop,
	output logic                             init_busy,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [tmcw_pkg::COL_W-1:0]       cursor_col,
	output logic [tmcw_pkg::ROW_W-1:0]       cursor_row,
	output logic [tmcw_pkg::DATA_W-1:0]      cell_data
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CLW   = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);
	localparam int XW    = (AW + 1 > tmcw_pkg::IDX_W) ? AW + 1 : tmcw_pkg::IDX_W;

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_EXEC   = 3'd2;
	localparam logic [2:0] ST_SCROLL = 3'd3;
	localparam logic [2:0] ST_SWEEP  = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [tmcw_pkg::DATA_W-1:0] mem [CELLS];
	logic [tmcw_pkg::DATA_W-1:0] rdata_q;

	logic [2:0]                  state_q;
	logic [tmcw_pkg::KIND_W-1:0] kind_q;
	logic [tmcw_pkg::CHAR_W-1:0] ch_q;
	logic [tmcw_pkg::IDX_W-1:0]  idx_q;
	logic [tmcw_pkg::TAB_W-1:0]  tab_left_q;
	logic                        rd_ok_q;

	logic [AW-1:0]  lin_q;
	logic [CLW-1:0] col_q;
	logic [RW-1:0]  row_q;
	logic [AW-1:0]  base_q;
	logic [AW-1:0]  clr_addr_q;
	logic [CLW-1:0] clr_cnt_q;
	logic [AW-1:0]  sweep_q;

	logic [tmcw_pkg::COL_W-1:0]  out_col_q;
	logic [tmcw_pkg::ROW_W-1:0]  out_row_q;
	logic [tmcw_pkg::DATA_W-1:0] out_data_q;
	logic                        out_valid_q;

	logic                        is_write;
	logic                        at_end;
	logic                        idx_ok;
	logic [AW-1:0]               lin_sel;
	logic [AW:0]                 phys_sum;
	logic [AW-1:0]               phys;
	logic [AW:0]                 base_sum;
	logic [AW-1:0]               base_nx;
	logic [AW:0]                 nl_lin;
	logic [tmcw_pkg::CHAR_W-1:0] wr_char;
	logic                        slot_free;
	logic                        mem_we;
	logic [AW-1:0]               mem_waddr;
	logic [tmcw_pkg::DATA_W-1:0] mem_wdata;
	logic                        mem_re;

	assign is_write  = (kind_q == tmcw_pkg::K_PUT) || (kind_q == tmcw_pkg::K_TAB);
	assign at_end    = (lin_q == AW'(CELLS - 1));
	assign idx_ok    = (XW'(idx_q) < XW'(CELLS));
	assign wr_char   = (kind_q == tmcw_pkg::K_TAB) ? tmcw_pkg::CH_SPACE : ch_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		case (kind_q)
			tmcw_pkg::K_BKSP: lin_sel = lin_q - 1'b1;
			tmcw_pkg::K_READ: lin_sel = AW'(idx_q);
			default:          lin_sel = lin_q;
		endcase
	end

	assign phys_sum = {1'b0, lin_sel} + {1'b0, base_q};
	assign phys     = (phys_sum >= (AW + 1)'(CELLS)) ? AW'(phys_sum - (AW + 1)'(CELLS))
							: AW'(phys_sum);
	assign base_sum = {1'b0, base_q} + (AW + 1)'(COLUMNS);
	assign base_nx  = (base_sum >= (AW + 1)'(CELLS)) ? AW'(base_sum - (AW + 1)'(CELLS))
							: AW'(base_sum);
	assign nl_lin   = (AW + 1)'(lin_q) - (AW + 1)'(col_q) + (AW + 1)'(COLUMNS);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = phys;
		mem_wdata = '0;
		mem_re    = 1'b0;
		case (state_q)
			ST_INIT, ST_SWEEP: begin
				mem_we    = 1'b1;
				mem_waddr = sweep_q;
			end
			ST_SCROLL: begin
				mem_we    = 1'b1;
				mem_waddr = clr_addr_q;
			end
			ST_EXEC: begin
				if (is_write) begin
					mem_we    = 1'b1;
					mem_wdata = {attr, wr_char};
				end else if (kind_q == tmcw_pkg::K_BKSP) begin
					mem_we = (lin_q != '0);
				end else if (kind_q == tmcw_pkg::K_READ) begin
					mem_re = idx_ok;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[phys];
		end
	end

	always_comb begin
		pop = 1'b0;
		case (state_q)
			ST_IDLE:   pop = !fifo_stat.empty;
			ST_FINISH: pop = slot_free && !fifo_stat.empty;
			default:   pop = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_q <= cmd.kind;
			ch_q   <= cmd.ch;
			idx_q  <= cmd.idx;
		end
		if (state_q == ST_EXEC) begin
			rd_ok_q <= idx_ok;
		end
		if (state_q == ST_FINISH && slot_free) begin
			out_col_q  <= tmcw_pkg::COL_W'(col_q);
			out_row_q  <= tmcw_pkg::ROW_W'(row_q);
			out_data_q <= (kind_q == tmcw_pkg::K_READ && rd_ok_q) ? rdata_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			tab_left_q  <= '0;
			lin_q       <= '0;
			col_q       <= '0;
			row_q       <= '0;
			base_q      <= '0;
			clr_addr_q  <= '0;
			clr_cnt_q   <= '0;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_FINISH && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_INIT: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == AW'(CELLS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pop) begin
						tab_left_q <= (cmd.kind == tmcw_pkg::K_TAB) ? tmcw_pkg::TAB_SPACES :
							(cmd.kind == tmcw_pkg::K_PUT) ? tmcw_pkg::TAB_W'(1) : '0;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (kind_q)
						tmcw_pkg::K_PUT, tmcw_pkg::K_TAB: begin
							tab_left_q <= tab_left_q - 1'b1;
							if (at_end) begin
								clr_addr_q <= base_q;
								clr_cnt_q  <= '0;
								base_q     <= base_nx;
								lin_q      <= AW'(CELLS - COLUMNS);
								row_q      <= RW'(ROWS - 1);
								col_q      <= '0;
								state_q    <= ST_SCROLL;
							end else begin
								lin_q <= lin_q + 1'b1;
								if (col_q == CLW'(COLUMNS - 1)) begin
									col_q <= '0;
									row_q <= row_q + 1'b1;
								end else begin
									col_q <= col_q + 1'b1;
								end
								state_q <= (tab_left_q != tmcw_pkg::TAB_W'(1)) ? ST_EXEC
									: ST_FINISH;
							end
						end
						tmcw_pkg::K_NEWLINE: begin
							if (row_q == RW'(ROWS - 1)) begin
								clr_addr_q <= base_q;
								clr_cnt_q  <= '0;
								base_q     <= base_nx;
								lin_q      <= AW'(CELLS - COLUMNS);
								col_q      <= '0;
								state_q    <= ST_SCROLL;
							end else begin
								lin_q   <= AW'(nl_lin);
								row_q   <= row_q + 1'b1;
								col_q   <= '0;
								state_q <= ST_FINISH;
							end
						end
						tmcw_pkg::K_BKSP: begin
							if (lin_q != '0) begin
								lin_q <= lin_q - 1'b1;
								if (col_q == '0) begin
									col_q <= CLW'(COLUMNS - 1);
									row_q <= row_q - 1'b1;
								end else begin
									col_q <= col_q - 1'b1;
								end
							end
							state_q <= ST_FINISH;
						end
						tmcw_pkg::K_CLEAR: begin
							sweep_q <= '0;
							state_q <= ST_SWEEP;
						end
						default: begin
							state_q <= ST_FINISH;
						end
					endcase
				end
				ST_SCROLL: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					clr_cnt_q  <= clr_cnt_q + 1'b1;
					if (clr_cnt_q == CLW'(COLUMNS - 1)) begin
						state_q <= (tab_left_q != '0) ? ST_EXEC : ST_FINISH;
					end
				end
				ST_SWEEP: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == AW'(CELLS - 1)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (slot_free) begin
						if (pop) begin
							tab_left_q <= (cmd.kind == tmcw_pkg::K_TAB) ? tmcw_pkg::TAB_SPACES :
								(cmd.kind == tmcw_pkg::K_PUT) ? tmcw_pkg::TAB_W'(1) : '0;
							state_q <= ST_EXEC;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign init_busy  = (state_q == ST_INIT);
	assign out_valid  = out_valid_q;
	assign cursor_col = out_col_q;
	assign cursor_row = out_row_q;
	assign cell_data  = out_data_q;

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_FINISH) |-> !mem_we)
		else $error("cell write outside execution");

	a_cursor_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		int'(lin_q) == int'(row_q) * COLUMNS + int'(col_q))
		else $error("linear cursor out of step with row and column");

	a_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(base_q) < CELLS)
		else $error("ring base out of range");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fifo_stat.empty)
		else $error("pop from empty queue");

	a_finish_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && slot_free) |=> out_valid_q)
		else $error("result not presented after finish");

endmodule

`default_nettype wire

/* src/text_mode_char_writer.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel   Handshake               Payload
// in        in_valid / in_ready     op, char_code, cell_index
// out       out_valid / out_ready   cursor_col, cursor_row, cell_data
// cfg       cfg_valid / cfg_ready   cfg_data (text attribute)
//
// After reset the cell memory is swept to zero, all COLUMNS*ROWS cells (2000 by default),
// with in_ready low. A scroll clears the new last row and a clear sweeps
// every cell, each through the single memory write port. A two-entry queue
// keeps in_ready high while the back end works or a result waits on
// out_ready, until two transfers wait.

module text_mode_char_writer #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [tmcw_pkg::OP_W-1:0]   op,
	input  wire logic [tmcw_pkg::CHAR_W-1:0] char_code,
	input  wire logic [tmcw_pkg::IDX_W-1:0]  cell_index,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [tmcw_pkg::COL_W-1:0]       cursor_col,
	output logic [tmcw_pkg::ROW_W-1:0]       cursor_row,
	output logic [tmcw_pkg::DATA_W-1:0]      cell_data,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [tmcw_pkg::ATTR_W-1:0] cfg_data
);

	logic [tmcw_pkg::ATTR_W-1:0] attr_q;
	logic                        push;
	logic                        pop;
	logic                        init_busy;
	tmcw_pkg::cmd_t              push_cmd;
	tmcw_pkg::cmd_t              pop_cmd;
	tmcw_pkg::fifo_stat_t        fifo_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= tmcw_pkg::ATTR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			attr_q <= cfg_data;
		end
	end

	tmcw_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.op         (op),
		.char_code  (char_code),
		.cell_index (cell_index),
		.fifo_stat  (fifo_stat),
		.init_busy  (init_busy),
		.push       (push),
		.cmd        (push_cmd)
	);

	tmcw_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.stat     (fifo_stat)
	);

	tmcw_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.attr       (attr_q),
		.fifo_stat  (fifo_stat),
		.cmd        (pop_cmd),
		.pop        (pop),
		.init_busy  (init_busy),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.cursor_col (cursor_col),
		.cursor_row (cursor_row),
		.cell_data  (cell_data)
	);

endmodule

`default_nettype wire
